FILE: rtl/cpos_pkg.sv
// Shared codes and default sizes for the closest-point-on-segment block.
package cpos_pkg;

   // Default coordinate width and quotient fraction width
   localparam int COORD_BITS_DEF    = 24;
   localparam int FRACTION_BITS_DEF = 16;

   // Where the nearest point lies on the segment
   typedef enum logic [1:0] {
      LANDED_START  = 2'd0,
      LANDED_END    = 2'd1,
      LANDED_INSIDE = 2'd2
   } landed_type;

   // Configuration register indexes
   typedef enum logic [1:0] {
      REG_START_X = 2'd0,
      REG_START_Y = 2'd1,
      REG_END_X   = 2'd2,
      REG_END_Y   = 2'd3
   } reg_index_type;

endpackage

FILE: rtl/cpos_front.sv
// Front pipeline: offsets, dot products and squared segment length.
module cpos_front import cpos_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   output logic                                 in_stall,
   input  logic signed [COORD_BITS-1:0]         point_x,
   input  logic signed [COORD_BITS-1:0]         point_y,
   input  logic signed [COORD_BITS-1:0]         start_x,
   input  logic signed [COORD_BITS-1:0]         start_y,
   input  logic signed [COORD_BITS-1:0]         end_x,
   input  logic signed [COORD_BITS-1:0]         end_y,
   output logic                                 out_valid,
   input  logic                                 out_stall,
   output logic signed [2*(COORD_BITS+1):0]     out_dot,
   output logic        [2*(COORD_BITS+1)-1:0]   out_den,
   output logic signed [COORD_BITS:0]           v_x,
   output logic signed [COORD_BITS:0]           v_y
);

   localparam int DW     = COORD_BITS + 1;
   localparam int PROD_W = 2 * DW;
   localparam int DOT_W  = PROD_W + 1;

   logic                     s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic                     s1_stall, s2_stall, s3_stall;
   logic signed [DW-1:0]     dx_ff, dy_ff, dx_in, dy_in;
   logic signed [DW-1:0]     v_x_ff, v_y_ff, v_x_in, v_y_in;
   logic signed [PROD_W-1:0] pxx_ff, pyy_ff, pxx_in, pyy_in;
   logic signed [PROD_W-1:0] vxx_ff, vyy_ff, vxx_in, vyy_in;
   logic signed [DOT_W-1:0]  dot_ff, dot_in;
   logic        [PROD_W-1:0] den_ff, den_in;

   // Hold a full stage while the one after it holds
   assign s3_stall = s3_valid_ff & out_stall;
   assign s2_stall = s2_valid_ff & s3_stall;
   assign s1_stall = s1_valid_ff & s2_stall;
   assign in_stall = s1_stall;

   // Offsets of the point and the segment end from the start
   always_comb begin
      dx_in  = $signed({point_x[COORD_BITS-1], point_x}) - $signed({start_x[COORD_BITS-1], start_x});
      dy_in  = $signed({point_y[COORD_BITS-1], point_y}) - $signed({start_y[COORD_BITS-1], start_y});
      v_x_in = $signed({end_x[COORD_BITS-1], end_x}) - $signed({start_x[COORD_BITS-1], start_x});
      v_y_in = $signed({end_y[COORD_BITS-1], end_y}) - $signed({start_y[COORD_BITS-1], start_y});
   end

   // Products, one multiplier per term
   always_comb begin
      pxx_in = dx_ff * v_x_ff;
      pyy_in = dy_ff * v_y_ff;
      vxx_in = v_x_ff * v_x_ff;
      vyy_in = v_y_ff * v_y_ff;
   end

   // Sums; the squared terms are never negative
   always_comb begin
      dot_in = $signed({pxx_ff[PROD_W-1], pxx_ff}) + $signed({pyy_ff[PROD_W-1], pyy_ff});
      den_in = $unsigned(vxx_ff) + $unsigned(vyy_ff);
   end

   // Segment terms run freely, in step with the item stages
   always_ff @(posedge clock) begin
      v_x_ff <= v_x_in;
      v_y_ff <= v_y_in;
      vxx_ff <= vxx_in;
      vyy_ff <= vyy_in;
      den_ff <= den_in;
   end

   // Advance item valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (!s1_stall) s1_valid_ff <= in_valid;
         if (!s2_stall) s2_valid_ff <= s1_valid_ff;
         if (!s3_stall) s3_valid_ff <= s2_valid_ff;
      end
   end

   // Advance item payload
   always_ff @(posedge clock) begin
      if (!s1_stall) begin
         dx_ff <= dx_in;
         dy_ff <= dy_in;
      end
      if (!s2_stall) begin
         pxx_ff <= pxx_in;
         pyy_ff <= pyy_in;
      end
      if (!s3_stall) dot_ff <= dot_in;
   end

   assign out_valid = s3_valid_ff;
   assign out_dot   = dot_ff;
   assign out_den   = den_ff;
   assign v_x       = v_x_ff;
   assign v_y       = v_y_ff;

endmodule

FILE: rtl/cpos_cell.sv
// One restoring division step of the quotient row.
module cpos_cell import cpos_pkg::*; #(
   parameter int REM_W         = 2 * (COORD_BITS_DEF + 1) + 1,
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_stall,
   input  landed_type                in_code,
   input  logic [REM_W-1:0]          in_rem,
   input  logic [FRACTION_BITS-1:0]  in_t,
   input  logic [REM_W-2:0]          den,
   output logic                      out_valid,
   input  logic                      out_stall,
   output landed_type                out_code,
   output logic [REM_W-1:0]          out_rem,
   output logic [FRACTION_BITS-1:0]  out_t
);

   logic                     valid_ff;
   logic                     stall;
   landed_type               code_ff;
   logic [REM_W-1:0]         rem_ff, rem_in, rem_dbl;
   logic [FRACTION_BITS-1:0] t_ff, t_in;
   logic                     take;

   assign stall    = valid_ff & out_stall;
   assign in_stall = stall;

   // Double the remainder, subtract the divisor where it fits
   always_comb begin
      rem_dbl = {in_rem[REM_W-2:0], 1'b0};
      take    = rem_dbl >= {1'b0, den};
      rem_in  = take ? (rem_dbl - {1'b0, den}) : rem_dbl;
      t_in    = {in_t[FRACTION_BITS-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!stall) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!stall) begin
         code_ff <= in_code;
         rem_ff  <= rem_in;
         t_ff    <= t_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_code  = code_ff;
   assign out_rem   = rem_ff;
   assign out_t     = t_ff;

endmodule

FILE: rtl/cpos_back.sv
// Back pipeline: scale the segment by the quotient, round and select result.
module cpos_back import cpos_pkg::*; #(
   parameter int COORD_BITS    = COORD_BITS_DEF,
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_stall,
   input  landed_type                    in_code,
   input  logic [FRACTION_BITS-1:0]      in_t,
   input  logic signed [COORD_BITS-1:0]  start_x,
   input  logic signed [COORD_BITS-1:0]  start_y,
   input  logic signed [COORD_BITS-1:0]  end_x,
   input  logic signed [COORD_BITS-1:0]  end_y,
   input  logic signed [COORD_BITS:0]    v_x,
   input  logic signed [COORD_BITS:0]    v_y,
   output logic                          out_valid,
   input  logic                          out_stall,
   output logic signed [COORD_BITS-1:0]  near_x,
   output logic signed [COORD_BITS-1:0]  near_y,
   output logic [1:0]                    where_landed
);

   localparam int DW = COORD_BITS + 1;
   localparam int PW = DW + FRACTION_BITS;
   localparam logic [PW:0] HALF = (PW + 1)'(1) << (FRACTION_BITS - 1);

   logic                   p_valid_ff, o_valid_ff;
   logic                   p_stall, o_stall;
   landed_type             p_code_ff, o_code_ff;
   logic [DW-1:0]          mag_x, mag_y;
   logic [PW-1:0]          prod_x_ff, prod_y_ff, prod_x_in, prod_y_in;
   logic [PW:0]            rnd_x, rnd_y;
   logic [DW-1:0]          r_x, r_y;
   logic signed [DW-1:0]   base_x, base_y, sum_x, sum_y;
   logic signed [COORD_BITS-1:0] near_x_ff, near_y_ff, near_x_in, near_y_in;

   assign o_stall  = o_valid_ff & out_stall;
   assign p_stall  = p_valid_ff & o_stall;
   assign in_stall = p_stall;

   // Scale the segment magnitude by the quotient
   always_comb begin
      mag_x     = v_x[DW-1] ? $unsigned(-v_x) : $unsigned(v_x);
      mag_y     = v_y[DW-1] ? $unsigned(-v_y) : $unsigned(v_y);
      prod_x_in = PW'(mag_x) * PW'(in_t);
      prod_y_in = PW'(mag_y) * PW'(in_t);
   end

   // Round half away from zero, then step from the start
   always_comb begin
      rnd_x  = {1'b0, prod_x_ff} + HALF;
      rnd_y  = {1'b0, prod_y_ff} + HALF;
      r_x    = rnd_x[FRACTION_BITS +: DW];
      r_y    = rnd_y[FRACTION_BITS +: DW];
      base_x = $signed({start_x[COORD_BITS-1], start_x});
      base_y = $signed({start_y[COORD_BITS-1], start_y});
      sum_x  = v_x[DW-1] ? (base_x - $signed(r_x)) : (base_x + $signed(r_x));
      sum_y  = v_y[DW-1] ? (base_y - $signed(r_y)) : (base_y + $signed(r_y));
   end

   // Pick start, end or interior point
   always_comb begin
      case (p_code_ff)
         LANDED_START: begin
            near_x_in = start_x;
            near_y_in = start_y;
         end
         LANDED_END: begin
            near_x_in = end_x;
            near_y_in = end_y;
         end
         LANDED_INSIDE: begin
            near_x_in = sum_x[COORD_BITS-1:0];
            near_y_in = sum_y[COORD_BITS-1:0];
         end
         default: begin
            near_x_in = start_x;
            near_y_in = start_y;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         if (!p_stall) p_valid_ff <= in_valid;
         if (!o_stall) o_valid_ff <= p_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (!p_stall) begin
         p_code_ff <= in_code;
         prod_x_ff <= prod_x_in;
         prod_y_ff <= prod_y_in;
      end
      if (!o_stall) begin
         o_code_ff <= p_code_ff;
         near_x_ff <= near_x_in;
         near_y_ff <= near_y_in;
      end
   end

   assign out_valid    = o_valid_ff;
   assign near_x       = near_x_ff;
   assign near_y       = near_y_ff;
   assign where_landed = o_code_ff;

endmodule

FILE: rtl/closest_point_on_segment.sv
// Top level: nearest point on a configured 2D segment to each query point.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/req_stall | req_point_x, req_point_y
//   rsp     | out       | rsp_valid/rsp_stall | rsp_near_x, rsp_near_y, rsp_where_landed
//   csr     | in        | csr_valid/csr_ready | csr_index, csr_data
//
// One item enters per cycle while req is not stalled; the pipeline holds three
// front stages, one division cell per quotient bit, a multiply stage and the
// output register.
// Reset is synchronous and clears the pipeline valid bits and the configuration registers.
// A stall on rsp holds only full stages; empty stages still fill, so req is
// stalled only once every stage holds an item.
module closest_point_on_segment import cpos_pkg::*; #(
   parameter int COORD_BITS    = COORD_BITS_DEF,
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COORD_BITS-1:0]  req_point_x,
   input  logic signed [COORD_BITS-1:0]  req_point_y,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [COORD_BITS-1:0]  rsp_near_x,
   output logic signed [COORD_BITS-1:0]  rsp_near_y,
   output logic [1:0]                    rsp_where_landed,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [1:0]                    csr_index,
   input  logic [COORD_BITS-1:0]         csr_data
);

   localparam int DW    = COORD_BITS + 1;
   localparam int DOT_W = 2 * DW + 1;
   localparam int REM_W = DOT_W;

   logic signed [COORD_BITS-1:0] start_x_ff, start_y_ff, end_x_ff, end_y_ff;

   logic                    fr_valid, fr_stall;
   logic signed [DOT_W-1:0] fr_dot;
   logic [2*DW-1:0]         fr_den;
   logic signed [DW-1:0]    seg_v_x, seg_v_y;

   logic                     cell_valid [0:FRACTION_BITS];
   logic                     cell_stall [0:FRACTION_BITS];
   landed_type               cell_code  [0:FRACTION_BITS];
   logic [REM_W-1:0]         cell_rem   [0:FRACTION_BITS];
   logic [FRACTION_BITS-1:0] cell_t     [0:FRACTION_BITS];

   // Configuration writes are always taken
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_x_ff <= '0;
         start_y_ff <= '0;
         end_x_ff   <= '0;
         end_y_ff   <= '0;
      end else if (csr_valid && csr_ready) begin
         case (reg_index_type'(csr_index))
            REG_START_X: start_x_ff <= $signed(csr_data);
            REG_START_Y: start_y_ff <= $signed(csr_data);
            REG_END_X:   end_x_ff   <= $signed(csr_data);
            REG_END_Y:   end_y_ff   <= $signed(csr_data);
            default: ;
         endcase
      end
   end

   cpos_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .point_x   (req_point_x),
      .point_y   (req_point_y),
      .start_x   (start_x_ff),
      .start_y   (start_y_ff),
      .end_x     (end_x_ff),
      .end_y     (end_y_ff),
      .out_valid (fr_valid),
      .out_stall (fr_stall),
      .out_dot   (fr_dot),
      .out_den   (fr_den),
      .v_x       (seg_v_x),
      .v_y       (seg_v_y)
   );

   // Classify against the ends; the interior case seeds the division
   always_comb begin
      if (fr_dot <= 0) begin
         cell_code[0] = LANDED_START;
      end else if ($signed({1'b0, fr_den}) <= fr_dot) begin
         cell_code[0] = LANDED_END;
      end else begin
         cell_code[0] = LANDED_INSIDE;
      end
      cell_valid[0] = fr_valid;
      cell_rem[0]   = $unsigned(fr_dot);
      cell_t[0]     = '0;
   end
   assign fr_stall = cell_stall[0];

   // Row of division cells, one quotient bit each
   for (genvar i = 0; i < FRACTION_BITS; i++) begin : g_cell
      cpos_cell #(.REM_W(REM_W), .FRACTION_BITS(FRACTION_BITS)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (cell_valid[i]),
         .in_stall  (cell_stall[i]),
         .in_code   (cell_code[i]),
         .in_rem    (cell_rem[i]),
         .in_t      (cell_t[i]),
         .den       (fr_den),
         .out_valid (cell_valid[i+1]),
         .out_stall (cell_stall[i+1]),
         .out_code  (cell_code[i+1]),
         .out_rem   (cell_rem[i+1]),
         .out_t     (cell_t[i+1])
      );
   end

   cpos_back #(.COORD_BITS(COORD_BITS), .FRACTION_BITS(FRACTION_BITS)) u_back (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (cell_valid[FRACTION_BITS]),
      .in_stall     (cell_stall[FRACTION_BITS]),
      .in_code      (cell_code[FRACTION_BITS]),
      .in_t         (cell_t[FRACTION_BITS]),
      .start_x      (start_x_ff),
      .start_y      (start_y_ff),
      .end_x        (end_x_ff),
      .end_y        (end_y_ff),
      .v_x          (seg_v_x),
      .v_y          (seg_v_y),
      .out_valid    (rsp_valid),
      .out_stall    (rsp_stall),
      .near_x       (rsp_near_x),
      .near_y       (rsp_near_y),
      .where_landed (rsp_where_landed)
   );

endmodule

FILE: rtl/cpos_checker.sv
// Port-level checks for the closest-point block, bound to the top level.
module cpos_checker import cpos_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic signed [COORD_BITS-1:0]  rsp_near_x,
   input logic signed [COORD_BITS-1:0]  rsp_near_y,
   input logic [1:0]                    rsp_where_landed
);

   // Reset leaves no item at the output
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high right after reset");

   // With the output empty, no stage can hold back the input
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("req_stall while the output stage is empty");

   // A stalled item stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_near_x)
         && $stable(rsp_near_y) && $stable(rsp_where_landed))
      else $error("stalled rsp item changed");

endmodule

bind closest_point_on_segment cpos_checker #(.COORD_BITS(COORD_BITS)) u_cpos_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_near_x       (rsp_near_x),
   .rsp_near_y       (rsp_near_y),
   .rsp_where_landed (rsp_where_landed)
);
